[rtl/core/dqs_pkg.sv]
// Shared codes, field widths and the result record of the deque with search.
`timescale 1ns / 1ps

package dqs_pkg;

   localparam int DQS_DEPTH = 64;

   localparam int FUNC_W  = 3;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int POS_W   = 7;
   localparam int LEN_W   = 7;

   // operation codes; the two unused codes act as a length query
   localparam logic [FUNC_W-1:0] FUNC_INS_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INS_REAR  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_DEL_FRONT = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DEL_REAR  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_LENGTH    = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH    = 3'd5;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

   typedef struct packed {
      logic              done;
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  position;
      logic [LEN_W-1:0]  length;
   } dqs_result_type;

endpackage

[rtl/core/double_ended_queue_with_search.sv]
// Top level of the bounded deque of 32-bit words with linear search.
`timescale 1ns / 1ps

// Usage:
//   Requests enter on the req_ channel: req_tuser carries the operation
//   (insert front, insert rear, delete front, delete rear, length, search)
//   and req_tdata the 32-bit word to insert or to look for. Every request
//   yields exactly one response on the rsp_ channel: rsp_tuser holds the
//   status, rsp_tdata the 1-based match position and the stored length.
//   One request is in work at a time. Inserts, deletes and length queries
//   are taken one a cycle while the output register is free; the response
//   is loaded into the output register at the accepting edge and is valid
//   in the next cycle, as is the not-found response of a search of an
//   empty store. Any other search reads the entry store one word a cycle
//   from the front (one memory read port, one compare a cycle), stops at
//   the first match or after the last stored entry, and loads its response
//   once the output register is free; only then is a new request taken.
//   Reset empties the queue at once; stored words are not cleared.
//   While the receiver stalls, the response waits in the output register;
//   the next request is still taken if that register is drained in the
//   same cycle, otherwise the request side waits.

module double_ended_queue_with_search #(
   parameter int DEPTH = dqs_pkg::DQS_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [2:0]  req_tuser,   // [2:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [6:0] position, [13:7] length, [15:14] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   import dqs_pkg::*;

   dqs_result_type     res;
   logic               out_free;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]  rsp_status_ff;
   logic [POS_W-1:0]   rsp_pos_ff;
   logic [LEN_W-1:0]   rsp_len_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   dqs_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_func  (req_tuser),
      .req_value (req_tdata),
      .out_free  (out_free),
      .res       (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.done) begin
         rsp_status_ff <= res.status;
         rsp_pos_ff    <= res.position;
         rsp_len_ff    <= res.length;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_len_ff, rsp_pos_ff};

endmodule

[rtl/core/dqs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/dqs_ctrl.sv]
// Deque sequencer: ring pointers, entry store and the front-to-rear search scan.
`timescale 1ns / 1ps

module dqs_ctrl #(
   parameter int DEPTH = dqs_pkg::DQS_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dqs_pkg::FUNC_W-1:0]    req_func,
   input  logic [dqs_pkg::VALUE_W-1:0]   req_value,
   input  logic                          out_free,
   output dqs_pkg::dqs_result_type       res
);

   import dqs_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = ((AW > CW) ? AW : CW) + 1;
   localparam int OW = (CW > LEN_W) ? CW : LEN_W;

   localparam logic [CW-1:0] DepthCount = CW'(DEPTH);
   localparam logic [AW-1:0] LastIdx    = AW'(DEPTH - 1);
   localparam logic [SW-1:0] DepthSum   = SW'(DEPTH);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_REPLY = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [AW-1:0]       front_ff, front_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [VALUE_W-1:0]  key_ff, key_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [CW-1:0]       issue_ff, issue_in;
   logic                pend_ff, pend_in;
   logic [CW-1:0]       pend_pos_ff, pend_pos_in;
   logic                found_ff, found_in;
   logic [CW-1:0]       hit_pos_ff, hit_pos_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic                rd_en;
   logic [VALUE_W-1:0]  rd_data;

   logic [AW-1:0]       front_prev;
   logic [AW-1:0]       front_next;
   logic [AW-1:0]       ptr_next;
   logic [SW-1:0]       rear_sum;
   logic [SW-1:0]       rear_wrap;
   logic [AW-1:0]       rear_addr;
   logic [OW-1:0]       len_wide;
   logic [OW-1:0]       pos_wide;
   logic                full;
   logic                empty;

   dqs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   assign front_prev = (front_ff == '0) ? LastIdx : front_ff - AW'(1);
   assign front_next = (front_ff == LastIdx) ? '0 : front_ff + AW'(1);
   assign ptr_next   = (ptr_ff == LastIdx) ? '0 : ptr_ff + AW'(1);

   // rear slot is front + count folded once into the ring
   assign rear_sum  = SW'(front_ff) + SW'(count_ff);
   assign rear_wrap = rear_sum - DepthSum;
   assign rear_addr = (rear_sum >= DepthSum) ? rear_wrap[AW-1:0] : rear_sum[AW-1:0];

   assign full  = (count_ff == DepthCount);
   assign empty = (count_ff == '0);

   assign len_wide = OW'(count_in);
   assign pos_wide = OW'(hit_pos_ff);

   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      key_in      = key_ff;
      ptr_in      = ptr_ff;
      issue_in    = issue_ff;
      pend_in     = pend_ff;
      pend_pos_in = pend_pos_ff;
      found_in    = found_ff;
      hit_pos_in  = hit_pos_ff;
      wr_en       = 1'b0;
      wr_addr     = rear_addr;
      rd_en       = 1'b0;
      req_ready   = 1'b0;
      res.done     = 1'b0;
      res.status   = STAT_OK;
      res.position = '0;
      res.length   = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               res.done = 1'b1;
               case (req_func)
                  FUNC_INS_FRONT: begin
                     if (full) begin
                        res.status = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = front_prev;
                        front_in = front_prev;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  FUNC_INS_REAR: begin
                     if (full) begin
                        res.status = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  FUNC_DEL_FRONT: begin
                     if (empty) begin
                        res.status = STAT_EMPTY;
                     end else begin
                        front_in = front_next;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  FUNC_DEL_REAR: begin
                     if (empty) begin
                        res.status = STAT_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  FUNC_SEARCH: begin
                     if (empty) begin
                        res.status = STAT_NOTFOUND;
                     end else begin
                        // hold the reply until the scan ends
                        res.done = 1'b0;
                        key_in   = req_value;
                        ptr_in   = front_ff;
                        issue_in = '0;
                        pend_in  = 1'b0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
               res.length = len_wide[LEN_W-1:0];
            end
         end

         ST_SCAN: begin
            // issue one read a cycle, compare the word that returns in the cycle after
            if (issue_ff != count_ff) begin
               rd_en       = 1'b1;
               ptr_in      = ptr_next;
               issue_in    = issue_ff + CW'(1);
               pend_in     = 1'b1;
               pend_pos_in = issue_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (rd_data == key_ff) begin
                  found_in   = 1'b1;
                  hit_pos_in = pend_pos_ff;
                  pend_in    = 1'b0;
                  state_in   = ST_REPLY;
               end else if (pend_pos_ff == count_ff) begin
                  found_in   = 1'b0;
                  hit_pos_in = '0;
                  pend_in    = 1'b0;
                  state_in   = ST_REPLY;
               end
            end
         end

         ST_REPLY: begin
            if (out_free) begin
               res.done     = 1'b1;
               res.status   = found_ff ? STAT_OK : STAT_NOTFOUND;
               res.position = pos_wide[POS_W-1:0];
               res.length   = len_wide[LEN_W-1:0];
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         front_ff <= '0;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      ptr_ff      <= ptr_in;
      issue_ff    <= issue_in;
      pend_pos_ff <= pend_pos_in;
      found_ff    <= found_in;
      hit_pos_ff  <= hit_pos_in;
   end

endmodule
